>>> rtl/hcd_pkg.sv
// Shared types, codes and character helpers for the chunked body decoder.
package hcd_pkg;

	// Parser phases
	localparam logic [2:0] PH_LEAD    = 3'd0;
	localparam logic [2:0] PH_DIGITS  = 3'd1;
	localparam logic [2:0] PH_TRAIL   = 3'd2;
	localparam logic [2:0] PH_EXT     = 3'd3;
	localparam logic [2:0] PH_LINE_LF = 3'd4;
	localparam logic [2:0] PH_DATA    = 3'd5;
	localparam logic [2:0] PH_DATA_CR = 3'd6;
	localparam logic [2:0] PH_DATA_LF = 3'd7;

	// Outcome codes
	localparam logic [1:0] OUT_NONE = 2'd0;
	localparam logic [1:0] OUT_OK   = 2'd1;
	localparam logic [1:0] OUT_ERR  = 2'd2;

	// Framing characters
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	localparam int DIGIT_MAX = 15;

	// One registered input beat
	typedef struct packed {
		logic [7:0] body_byte;
		logic       first_of_body;
		logic       last_of_body;
	} in_beat_t;

	// Hex digit decode: valid flag in bit 4, value in bits 3:0
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

endpackage

>>> rtl/hcd_in_stage.sv
// Input register stage: captures one stream beat and hands it to the parser.
module hcd_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,   // [7:0] body_byte
	input  logic             s_axis_tuser,   // [0] first_of_body
	input  logic             s_axis_tlast,   // last_of_body
	output logic             valid_s1,
	output hcd_pkg::in_beat_t beat_s1,
	input  logic             advance
);

	// Take a new beat when empty or when the held beat moves on this cycle
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			beat_s1.body_byte     <= s_axis_tdata;
			beat_s1.first_of_body <= s_axis_tuser;
			beat_s1.last_of_body  <= s_axis_tlast;
		end
	end

endmodule

>>> rtl/hcd_core.sv
// Chunk framing parser with its state and the result register.
module hcd_core #(
	parameter int SIZE_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  hcd_pkg::in_beat_t beat_s1,
	output logic             advance,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,
	output logic [2:0]       m_axis_tuser
);

	logic [2:0]           phase_q;
	logic [SIZE_BITS-1:0] remain_q;
	logic [3:0]           digits_q;
	logic                 reported_q;

	logic [2:0]           phase_d;
	logic [SIZE_BITS-1:0] remain_d;
	logic [3:0]           digits_d;
	logic                 reported_d;
	logic                 pvalid_d;
	logic [7:0]           pbyte_d;
	logic [1:0]           outcome_d;

	logic [2:0]           phase_e;
	logic [SIZE_BITS-1:0] remain_e;
	logic [3:0]           digits_e;
	logic                 reported_e;

	logic [7:0]           c;
	logic [4:0]           hx;
	logic                 ovf;
	logic                 err;
	logic                 done;
	logic [SIZE_BITS-1:0] shifted;
	logic [SIZE_BITS-1:0] dec;
	logic [3:0]           digits_inc;

	assign advance = valid_s1 && (!m_axis_tvalid || m_axis_tready);

	always_comb begin
		c = beat_s1.body_byte;
		// New body: start from cleared state
		phase_e    = beat_s1.first_of_body ? hcd_pkg::PH_LEAD : phase_q;
		remain_e   = beat_s1.first_of_body ? '0 : remain_q;
		digits_e   = beat_s1.first_of_body ? 4'd0 : digits_q;
		reported_e = beat_s1.first_of_body ? 1'b0 : reported_q;

		hx         = hcd_pkg::hex_decode(c);
		ovf        = remain_e[SIZE_BITS-1 -: 4] != 4'd0;
		shifted    = {remain_e[SIZE_BITS-5:0], hx[3:0]};
		dec        = (remain_e != '0) ? remain_e - {{(SIZE_BITS-1){1'b0}}, 1'b1} : remain_e;
		digits_inc = (digits_e < 4'(hcd_pkg::DIGIT_MAX)) ? digits_e + 4'd1 : digits_e;

		phase_d    = phase_e;
		remain_d   = remain_e;
		digits_d   = digits_e;
		reported_d = reported_e;
		pvalid_d   = 1'b0;
		pbyte_d    = 8'd0;
		outcome_d  = hcd_pkg::OUT_NONE;
		err        = 1'b0;
		done       = 1'b0;

		if (!reported_e) begin
			case (phase_e)
				hcd_pkg::PH_LEAD: begin
					if (hcd_pkg::is_blank(c)) begin
					end else if (hx[4]) begin
						if (ovf) begin
							err = 1'b1;
						end else begin
							remain_d = shifted;
							digits_d = digits_inc;
							phase_d  = hcd_pkg::PH_DIGITS;
						end
					end else begin
						err = 1'b1;
					end
				end
				hcd_pkg::PH_DIGITS: begin
					if (hx[4]) begin
						if (ovf) begin
							err = 1'b1;
						end else begin
							remain_d = shifted;
							digits_d = digits_inc;
						end
					end else if (hcd_pkg::is_blank(c)) begin
						phase_d = hcd_pkg::PH_TRAIL;
					end else if (c == hcd_pkg::CH_SEMI) begin
						phase_d = hcd_pkg::PH_EXT;
					end else if (c == hcd_pkg::CH_CR) begin
						phase_d = hcd_pkg::PH_LINE_LF;
					end else begin
						err = 1'b1;
					end
				end
				hcd_pkg::PH_TRAIL: begin
					if (hcd_pkg::is_blank(c)) begin
					end else if (c == hcd_pkg::CH_SEMI) begin
						phase_d = hcd_pkg::PH_EXT;
					end else if (c == hcd_pkg::CH_CR) begin
						phase_d = hcd_pkg::PH_LINE_LF;
					end else begin
						err = 1'b1;
					end
				end
				hcd_pkg::PH_EXT: begin
					if (c == hcd_pkg::CH_CR) begin
						phase_d = hcd_pkg::PH_LINE_LF;
					end
				end
				hcd_pkg::PH_LINE_LF: begin
					if (c != hcd_pkg::CH_LF || digits_e == 4'd0) begin
						err = 1'b1;
					end else if (remain_e == '0) begin
						done = 1'b1;
					end else begin
						phase_d = hcd_pkg::PH_DATA;
					end
				end
				hcd_pkg::PH_DATA: begin
					pvalid_d = 1'b1;
					pbyte_d  = c;
					remain_d = dec;
					if (dec == '0) begin
						phase_d = hcd_pkg::PH_DATA_CR;
					end
				end
				hcd_pkg::PH_DATA_CR: begin
					if (c == hcd_pkg::CH_CR) begin
						phase_d = hcd_pkg::PH_DATA_LF;
					end else begin
						err = 1'b1;
					end
				end
				default: begin
					if (c == hcd_pkg::CH_LF) begin
						phase_d  = hcd_pkg::PH_LEAD;
						remain_d = '0;
						digits_d = 4'd0;
					end else begin
						err = 1'b1;
					end
				end
			endcase

			if (done) begin
				outcome_d = hcd_pkg::OUT_OK;
			end else if (err || beat_s1.last_of_body) begin
				outcome_d = hcd_pkg::OUT_ERR;
			end
			if (outcome_d != hcd_pkg::OUT_NONE) begin
				reported_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= hcd_pkg::PH_LEAD;
			remain_q      <= '0;
			digits_q      <= 4'd0;
			reported_q    <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (advance) begin
				phase_q    <= phase_d;
				remain_q   <= remain_d;
				digits_q   <= digits_d;
				reported_q <= reported_d;
			end
			if (!m_axis_tvalid || m_axis_tready) begin
				m_axis_tvalid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_axis_tdata <= pbyte_d;
			m_axis_tuser <= {outcome_d, pvalid_d};
		end
	end

endmodule

>>> rtl/http_chunked_body_decoder_top.sv
// Top level of the chunked transfer body decoder.
// Path: an accepted input beat goes through the input register, then the parser logic
// into the result register, which holds its result beat.
// Throughput: one beat per cycle while the result register is empty or being drained;
// both stages advance together then, and a stalled output holds both stages.
// Reset: arst_n clears the parser to the start of a size line, with no pending beats.
module http_chunked_body_decoder_top #(
	parameter int SIZE_BITS = 32   // width of the chunk size counter, 8 to 64
) (
	input  logic       clk,
	input  logic       arst_n,
	// Raw body beats
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] body_byte
	input  logic       s_axis_tuser,   // [0] first_of_body
	input  logic       s_axis_tlast,   // last_of_body
	// Decoded result beats, one per input beat
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
	output logic [2:0] m_axis_tuser    // [0] payload_valid, [2:1] outcome
);

	logic              valid_s1;
	hcd_pkg::in_beat_t beat_s1;
	logic              advance;

	// Stage one: hold the incoming beat; refill in the same cycle it moves on
	hcd_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.valid_s1      (valid_s1),
		.beat_s1       (beat_s1),
		.advance       (advance)
	);

	// Stage two: parse the held byte against the framing state and register the
	// result; the framing state only advances when the beat moves into the result
	// register, so a stalled output never double-counts a byte
	hcd_core #(
		.SIZE_BITS (SIZE_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.beat_s1       (beat_s1),
		.advance       (advance),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
